// ===== hw/rtl/sync_length_packet_deframer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// sync length packet deframer - assertion macros
// Concurrent assertion wrappers shared by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define SYNC_LENGTH_PACKET_DEFRAMER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define SLPD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked at every edge, reset included
`define SLPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SLPD_ASSERT(lbl, clk, rst_n, prop, msg)
`define SLPD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/slpd_pkg.sv =====
// ----------------------------------------------------------------------------
// slpd_pkg
// Types and constants of the sync length packet deframer.
// ----------------------------------------------------------------------------
package slpd_pkg;

  localparam logic [7:0] SYNC_RESET = 8'hAA;

  typedef enum logic [2:0] {
    PH_SYNC    = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_COMMAND = 3'd2,
    PH_DATA    = 3'd3,
    PH_CHECK   = 3'd4,
    PH_EMIT    = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] sync_value;
  } cfg_item_t;

  typedef struct packed {
    logic [7:0] command;
    logic [7:0] length;
    logic [7:0] checksum;
    logic [7:0] payload_byte;
    logic [4:0] payload_index;
    logic       payload_valid;
    logic       truncated;
    logic       last;
  } out_item_t;

  // control from the parser to the payload chain
  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_idx;
    logic [7:0] wr_data;
    logic       shift;
  } chain_ctrl_t;

endpackage

// ===== hw/rtl/slpd_stream_if.sv =====
// ----------------------------------------------------------------------------
// slpd_stream_if
// Valid/ready channel carrying one item of a chosen type.
// ----------------------------------------------------------------------------
interface slpd_stream_if #(
  parameter type item_t = logic [7:0]
) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/slpd_cell.sv =====
// ----------------------------------------------------------------------------
// slpd_cell
// One payload byte of the storage chain: loads a received byte or takes
// its neighbor's byte when the chain shifts toward the head.
// ----------------------------------------------------------------------------
module slpd_cell (
  input  logic       clk,
  input  logic       we,
  input  logic [7:0] wdata,
  input  logic       shift,
  input  logic [7:0] next_q,
  output logic [7:0] q
);

  logic [7:0] q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      q_r <= wdata;
    end else if (shift) begin
      q_r <= next_q;
    end
  end

  assign q = q_r;

endmodule

// ===== hw/rtl/slpd_chain.sv =====
// ----------------------------------------------------------------------------
// slpd_chain
// Row of payload cells. Bytes are written at their payload position; on
// readout the row shifts one cell toward the head for each result.
// ----------------------------------------------------------------------------
module slpd_chain #(
  parameter int DEPTH = 32
) (
  input  logic                 clk,
  input  slpd_pkg::chain_ctrl_t ctrl,
  output logic [7:0]           head
);

  logic [7:0] q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [7:0] nxt;
    logic       we;

    if (i == DEPTH - 1) begin : g_tail
      assign nxt = 8'h00;
    end else begin : g_mid
      assign nxt = q[i + 1];
    end

    assign we = ctrl.wr_en && (ctrl.wr_idx == 8'(i));

    slpd_cell u_cell (
      .clk    (clk),
      .we     (we),
      .wdata  (ctrl.wr_data),
      .shift  (ctrl.shift),
      .next_q (nxt),
      .q      (q[i])
    );
  end

  assign head = q[0];

endmodule

// ===== hw/rtl/sync_length_packet_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// sync_length_packet_deframer_unit
// Sync / length / command / payload / checksum packet parser.
// ----------------------------------------------------------------------------
// Received bytes are taken one per cycle while no packet is being read out.
// The parser hunts for the sync byte (register, reset 0xAA), then takes a
// length byte, a command byte, that many payload bytes and a checksum byte.
// Up to MAX_PAYLOAD payload bytes are kept in a row of byte cells; extra bytes
// are consumed and dropped and the packet is flagged truncated. The checksum
// byte starts a readout run of max(1, min(length, MAX_PAYLOAD, 32)) results,
// one per cycle while the sink is ready, with the last one marked; the row of
// cells shifts one place toward its head per result, so the run length and
// the sink's stalls set how long the run lasts. No input is accepted during a
// run. The checksum is passed through and not verified.
// ----------------------------------------------------------------------------
`include "sync_length_packet_deframer_unit_macros.svh"

module sync_length_packet_deframer_unit #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  slpd_stream_if.sink       in_bus,
  slpd_stream_if.source     out_bus,
  slpd_stream_if.sink       cfg_bus
);

  localparam int         RUN_CAP   = (MAX_PAYLOAD < 32) ? MAX_PAYLOAD : 32;
  localparam logic [7:0] DEPTH_B   = 8'(MAX_PAYLOAD);
  localparam logic [7:0] RUN_CAP_B = 8'(RUN_CAP);

  slpd_pkg::phase_t      phase_r, phase_nxt;
  logic [7:0]            sync_r;
  logic [7:0]            length_r, length_nxt;
  logic [7:0]            command_r, command_nxt;
  logic [7:0]            rcvd_r, rcvd_nxt;
  logic [7:0]            checksum_r, checksum_nxt;
  logic [5:0]            count_r, count_nxt;
  logic                  trunc_r, trunc_nxt;
  logic [4:0]            idx_r, idx_nxt;
  slpd_pkg::chain_ctrl_t ctrl;
  logic [7:0]            head;
  logic [7:0]            rx;
  logic                  in_acc;
  logic                  out_acc;
  logic                  run_last;
  logic                  has_data;

  assign rx       = in_bus.data.rx_byte;
  assign in_acc   = in_bus.valid && in_bus.ready;
  assign out_acc  = out_bus.valid && out_bus.ready;
  assign has_data = (count_r != 6'd0);
  assign run_last = !has_data || (({1'b0, idx_r} + 6'd1) == count_r);

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= slpd_pkg::SYNC_RESET;
    end else if (cfg_bus.valid) begin
      sync_r <= cfg_bus.data.sync_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= slpd_pkg::PH_SYNC;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r   <= 8'h00;
      command_r  <= 8'h00;
      rcvd_r     <= 8'h00;
      count_r    <= 6'd0;
      trunc_r    <= 1'b0;
      idx_r      <= 5'd0;
    end else begin
      length_r   <= length_nxt;
      command_r  <= command_nxt;
      rcvd_r     <= rcvd_nxt;
      count_r    <= count_nxt;
      trunc_r    <= trunc_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    checksum_r <= checksum_nxt;
  end

  always_comb begin
    phase_nxt     = phase_r;
    length_nxt    = length_r;
    command_nxt   = command_r;
    rcvd_nxt      = rcvd_r;
    checksum_nxt  = checksum_r;
    count_nxt     = count_r;
    trunc_nxt     = trunc_r;
    idx_nxt       = idx_r;
    ctrl.wr_en    = 1'b0;
    ctrl.wr_idx   = rcvd_r;
    ctrl.wr_data  = rx;
    ctrl.shift    = 1'b0;
    in_bus.ready  = 1'b1;
    out_bus.valid = 1'b0;

    case (phase_r)
      slpd_pkg::PH_LENGTH: begin
        if (in_acc) begin
          length_nxt = rx;
          phase_nxt  = slpd_pkg::PH_COMMAND;
        end
      end
      slpd_pkg::PH_COMMAND: begin
        if (in_acc) begin
          command_nxt = rx;
          rcvd_nxt    = 8'h00;
          phase_nxt   = (length_r != 8'h00) ? slpd_pkg::PH_DATA : slpd_pkg::PH_CHECK;
        end
      end
      slpd_pkg::PH_DATA: begin
        if (in_acc) begin
          ctrl.wr_en = (rcvd_r < DEPTH_B);
          rcvd_nxt   = rcvd_r + 8'd1;
          if ((rcvd_r + 8'd1) >= length_r) begin
            phase_nxt = slpd_pkg::PH_CHECK;
          end
        end
      end
      slpd_pkg::PH_CHECK: begin
        if (in_acc) begin
          checksum_nxt = rx;
          trunc_nxt    = (length_r > RUN_CAP_B);
          count_nxt    = (length_r > RUN_CAP_B) ? RUN_CAP_B[5:0] : length_r[5:0];
          idx_nxt      = 5'd0;
          phase_nxt    = slpd_pkg::PH_EMIT;
        end
      end
      slpd_pkg::PH_EMIT: begin
        in_bus.ready  = 1'b0;
        out_bus.valid = 1'b1;
        if (out_acc) begin
          ctrl.shift = has_data;
          if (run_last) begin
            phase_nxt = slpd_pkg::PH_SYNC;
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      default: begin
        // sync hunt, also taken by codes with no meaning
        if (in_acc) begin
          phase_nxt = (rx == sync_r) ? slpd_pkg::PH_LENGTH : slpd_pkg::PH_SYNC;
        end
      end
    endcase
  end

  slpd_chain #(
    .DEPTH (MAX_PAYLOAD)
  ) u_chain (
    .clk  (clk),
    .ctrl (ctrl),
    .head (head)
  );

  assign out_bus.data.command       = command_r;
  assign out_bus.data.length        = length_r;
  assign out_bus.data.checksum      = checksum_r;
  assign out_bus.data.payload_byte  = has_data ? head : 8'h00;
  assign out_bus.data.payload_index = has_data ? idx_r : 5'd0;
  assign out_bus.data.payload_valid = has_data;
  assign out_bus.data.truncated     = trunc_r;
  assign out_bus.data.last          = run_last;

  // end of a run hands the input side back
  `SLPD_ASSERT(a_last_frees_input, clk, rst_n, out_acc && out_bus.data.last |=> in_bus.ready, "input not freed after last result")
  // a taken result that is not last is followed by the next position
  `SLPD_ASSERT(a_run_continues, clk, rst_n, out_acc && !out_bus.data.last |=> out_bus.valid && (out_bus.data.payload_index == $past(out_bus.data.payload_index) + 5'd1), "run broke off or skipped a position")
  // checksum byte always starts a run
  `SLPD_ASSERT(a_check_starts_run, clk, rst_n, in_acc && (phase_r == slpd_pkg::PH_CHECK) |=> out_bus.valid, "checksum byte gave no result")
  // truncation only for packets longer than the run cap
  `SLPD_ASSERT(a_trunc_len, clk, rst_n, out_bus.valid && out_bus.data.truncated |-> out_bus.data.length > RUN_CAP_B, "truncated flag on a short packet")
  // during reset nothing is offered
  `SLPD_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_bus.valid, "result offered right after reset")

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sync length packet deframer. Bytes go in over
// a valid/ready channel with bursty gaps, records come out under a stalling
// sink. A behavioral parser tracks sync hunting, header, payload and checksum
// and queues the records each byte should produce. The run covers several
// sync values, empty, short, full and overlong packets, noise and cut frames.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH    = 32;
  localparam int RUN_CAP  = (DEPTH < 32) ? DEPTH : 32;
  localparam int SETTLE   = 16;
  localparam int LONG_OFF = 150;

  typedef struct {
    logic [7:0]          rx;
    bit                  fixed;
    slpd_pkg::out_item_t rec;
  } stim_row_t;

  logic clk;
  logic rst_n;

  slpd_stream_if #(.item_t(slpd_pkg::in_item_t))  in_if ();
  slpd_stream_if #(.item_t(slpd_pkg::out_item_t)) out_if ();
  slpd_stream_if #(.item_t(slpd_pkg::cfg_item_t)) cfg_if ();

  sync_length_packet_deframer_unit #(
    .MAX_PAYLOAD(DEPTH)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  // parser copy
  logic [7:0]        sync_copy   = slpd_pkg::SYNC_RESET;
  slpd_pkg::phase_t  rx_phase    = slpd_pkg::PH_SYNC;
  logic [7:0]        hdr_length  = '0;
  logic [7:0]        hdr_command = '0;
  logic [7:0]        data_count  = '0;
  logic [7:0]        payload_mem [DEPTH];

  slpd_pkg::out_item_t packet_records_q [$];
  int                  err_count = 0;

  // typed record that replaces the parser's output for one request
  bit                  fixed_pending = 1'b0;
  slpd_pkg::out_item_t fixed_record;

  // stimulus side
  logic [7:0]  stim_sync = slpd_pkg::SYNC_RESET;
  int unsigned rx_sent   = 0;
  int unsigned burst_left = 0;
  bit          stall_req = 1'b0;

  stim_row_t directed_rows [22] = '{
    '{8'h00, 1'b0, '0},   // noise while hunting
    '{8'hFF, 1'b0, '0},
    '{8'hAA, 1'b0, '0},
    '{8'h00, 1'b0, '0},   // empty packet
    '{8'hFF, 1'b0, '0},
    '{8'h5A, 1'b1, '{8'hFF, 8'h00, 8'h5A, 8'h00, 5'd0, 1'b0, 1'b0, 1'b1}},
    '{8'hAA, 1'b0, '0},
    '{8'h03, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hAA, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hAA, 1'b0, '0},
    '{8'h00, 1'b0, '0},   // sync value reused as command
    '{8'hAA, 1'b0, '0},
    '{8'h01, 1'b1, '{8'hAA, 8'h00, 8'h01, 8'h00, 5'd0, 1'b0, 1'b0, 1'b1}}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL sync_length_packet_deframer_unit");
    $finish;
  end

  function automatic void parse_rx_byte(input logic [7:0] b,
                                        output slpd_pkg::out_item_t run [$]);
    slpd_pkg::out_item_t r;
    int unsigned         cnt;
    logic                trunc;
    run.delete();
    case (rx_phase)
      slpd_pkg::PH_LENGTH: begin
        hdr_length = b;
        rx_phase   = slpd_pkg::PH_COMMAND;
      end
      slpd_pkg::PH_COMMAND: begin
        hdr_command = b;
        data_count  = '0;
        rx_phase    = (hdr_length > 0) ? slpd_pkg::PH_DATA : slpd_pkg::PH_CHECK;
      end
      slpd_pkg::PH_DATA: begin
        if (data_count < DEPTH) payload_mem[data_count[$clog2(DEPTH)-1:0]] = b;
        data_count = data_count + 8'd1;
        if (data_count >= hdr_length) rx_phase = slpd_pkg::PH_CHECK;
      end
      slpd_pkg::PH_CHECK: begin
        cnt   = 32'(hdr_length);
        trunc = 1'b0;
        if (cnt > RUN_CAP) begin
          cnt   = RUN_CAP;
          trunc = 1'b1;
        end
        r.command  = hdr_command;
        r.length   = hdr_length;
        r.checksum = b;
        if (cnt == 0) begin
          r.payload_byte  = '0;
          r.payload_index = '0;
          r.payload_valid = 1'b0;
          r.truncated     = 1'b0;
          r.last          = 1'b1;
          run.push_back(r);
        end else begin
          for (int unsigned k = 0; k < cnt; k++) begin
            r.payload_byte  = payload_mem[k[$clog2(DEPTH)-1:0]];
            r.payload_index = k[4:0];
            r.payload_valid = 1'b1;
            r.truncated     = trunc;
            r.last          = (k + 1 == cnt);
            run.push_back(r);
          end
        end
        rx_phase = slpd_pkg::PH_SYNC;
      end
      default: rx_phase = (b == sync_copy) ? slpd_pkg::PH_LENGTH : slpd_pkg::PH_SYNC;
    endcase
  endfunction

  function automatic string show(input slpd_pkg::out_item_t r);
    return $sformatf("cmd=%h len=%h chk=%h data=%h idx=%0d vld=%b trn=%b last=%b",
                     r.command, r.length, r.checksum, r.payload_byte,
                     r.payload_index, r.payload_valid, r.truncated, r.last);
  endfunction

  function automatic void note_failure(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endfunction

  // requests in, then records out, evaluated on the same edge in one process
  always @(posedge clk) begin : monitor
    slpd_pkg::out_item_t run [$];
    slpd_pkg::out_item_t want;
    slpd_pkg::out_item_t got;
    string               bad;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sync_copy = cfg_if.data.sync_value;
      if (in_if.valid && in_if.ready) begin
        parse_rx_byte(in_if.data.rx_byte, run);
        if (fixed_pending) begin
          fixed_pending = 1'b0;
          packet_records_q.push_back(fixed_record);
        end else begin
          foreach (run[i]) packet_records_q.push_back(run[i]);
        end
      end
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (packet_records_q.size() == 0) begin
          note_failure($sformatf("unexpected record: %s", show(got)));
        end else begin
          want = packet_records_q.pop_front();
          bad  = "";
          if (got.command       !== want.command)       bad = {bad, " command"};
          if (got.length        !== want.length)        bad = {bad, " length"};
          if (got.checksum      !== want.checksum)      bad = {bad, " checksum"};
          if (got.payload_byte  !== want.payload_byte)  bad = {bad, " payload_byte"};
          if (got.payload_index !== want.payload_index) bad = {bad, " payload_index"};
          if (got.payload_valid !== want.payload_valid) bad = {bad, " payload_valid"};
          if (got.truncated     !== want.truncated)     bad = {bad, " truncated"};
          if (got.last          !== want.last)          bad = {bad, " last"};
          if (bad != "")
            note_failure($sformatf("mismatch on%s\n  exp %s\n  got %s",
                                   bad, show(want), show(got)));
        end
      end
    end
  end

  // sink: shifting stall patterns plus a long hold-off on request
  initial begin : sink_side
    int unsigned hold_left;
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (stall_req) begin
        stall_req = 1'b0;
        hold_left = LONG_OFF;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 1) == 1);
          2: out_if.ready <= ($urandom_range(0, 99) < 85);
          default: out_if.ready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_if.valid   <= 1'b1;
    in_if.data    <= '{rx_byte: b};
    do @(posedge clk); while (!in_if.ready);
    burst_left--;
  endtask

  task automatic write_sync(input logic [7:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{sync_value: v};
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    stim_sync = v;
  endtask

  // cut > 0 stops the frame early, leaving the parser mid-packet
  task automatic send_packet(input int unsigned len, input bit cut);
    int unsigned stop;
    logic [7:0]  b;
    stop = cut ? $urandom_range(1, len + 3) : len + 4;
    for (int unsigned i = 0; i < stop; i++) begin
      if (i == 0)      b = stim_sync;
      else if (i == 1) b = len[7:0];
      else             b = 8'($urandom_range(0, 255));
      push_byte(b);
      rx_sent++;
    end
  endtask

  // close any open frame with zero bytes, then wait for all records
  task automatic drain_to_idle();
    int unsigned n;
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    case (rx_phase)
      slpd_pkg::PH_LENGTH:  n = 3;
      slpd_pkg::PH_COMMAND: n = (hdr_length > 0) ? hdr_length + 2 : 2;
      slpd_pkg::PH_DATA:    n = hdr_length - data_count + 1;
      slpd_pkg::PH_CHECK:   n = 1;
      default:              n = 0;
    endcase
    repeat (n) push_byte(8'h00);
    in_if.valid <= 1'b0;
    // let the parser copy take the last request before looking at the queue
    @(posedge clk);
    while (packet_records_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [7:0]  sync_plan [5];
    logic [7:0]  b;
    int unsigned pick;
    int unsigned len;
    int unsigned phase_start;
    sync_plan = '{8'h00, 8'hFF, 8'h00, 8'h5A, 8'hAA};
    sync_plan[2] = 8'($urandom_range(0, 255));

    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].fixed) begin
        fixed_record  <= directed_rows[i].rec;
        fixed_pending <= 1'b1;
      end
      push_byte(directed_rows[i].rx);
    end
    drain_to_idle();

    for (int p = 0; p < 5; p++) begin
      write_sync(sync_plan[p]);
      if (p == 1) begin
        // sink holds off while frames keep coming, so the input backs up
        stall_req = 1'b1;
        send_packet(12, 1'b0);
        send_packet(0, 1'b0);
      end
      if (p == 2) begin
        send_packet(33, 1'b0);
      end
      phase_start = rx_sent;
      while (rx_sent - phase_start < 8) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          repeat ($urandom_range(1, 3)) begin
            do b = 8'($urandom_range(0, 255)); while (b == stim_sync);
            push_byte(b);
          end
        end else begin
          len = $urandom_range(0, 99);
          if (len < 15)      len = 0;
          else if (len < 80) len = $urandom_range(1, 6);
          else if (len < 93) len = $urandom_range(7, 31);
          else               len = $urandom_range(32, 40);
          send_packet(len, pick < 20);
        end
      end
      drain_to_idle();
    end

    if (packet_records_q.size() != 0)
      note_failure($sformatf("%0d records never arrived", packet_records_q.size()));
    if (err_count == 0) begin
      $display("PASS sync_length_packet_deframer_unit");
    end else begin
      $display("FAIL sync_length_packet_deframer_unit");
    end
    $finish;
  end

endmodule
